// ===== rtl/assert_macros.svh =====
// Assertion helpers; clocked on clk, quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TPS_ASSERT(lbl, prop, msg)
`define TPS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/tps_pkg.sv =====
package tps_pkg;

    localparam int CRD_W  = 24;            // corner coordinate
    localparam int N_CRD  = 9;
    localparam int DIF_W  = CRD_W + 1;     // edge component
    localparam int PRD_W  = 2 * DIF_W;     // product of edge components
    localparam int N_PRD  = 15;
    localparam int CR_W   = PRD_W + 1;     // cross product component
    localparam int DOT_W  = PRD_W + 2;     // dot product
    localparam int N_W    = DOT_W + 2;     // signed entry numerator
    localparam int MAG_W  = 52;            // numerator or cross magnitude
    localparam int HLF_W  = MAG_W / 2;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int D_W    = SQ_W + 2;      // Gram determinant
    localparam int N_ENT  = 6;
    localparam int N_SQ   = 3 + N_ENT;
    localparam int OUT_W  = 32;
    localparam int Y_W    = OUT_W + 1;     // root search width
    localparam int P_W    = D_W + Y_W;
    localparam int X_W    = P_W + Y_W + 2;

    typedef struct packed {
        logic             valid;
        logic             degen;
        logic [N_ENT-1:0] neg;
    } ctl_t;

endpackage

// ===== rtl/tps_geom.sv =====
module tps_geom
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [tps_pkg::N_CRD*tps_pkg::CRD_W-1:0] in_data,
    input  logic                          planar,
    output tps_pkg::ctl_t                 out_ctl,
    output logic [tps_pkg::D_W-1:0]       out_d,
    output logic [tps_pkg::SQ_W-1:0]      out_m2 [0:tps_pkg::N_ENT-1]
);

    localparam int CRD_W = tps_pkg::CRD_W;
    localparam int DIF_W = tps_pkg::DIF_W;
    localparam int PRD_W = tps_pkg::PRD_W;
    localparam int CR_W  = tps_pkg::CR_W;
    localparam int DOT_W = tps_pkg::DOT_W;
    localparam int N_W   = tps_pkg::N_W;
    localparam int MAG_W = tps_pkg::MAG_W;
    localparam int HLF_W = tps_pkg::HLF_W;
    localparam int SQ_W  = tps_pkg::SQ_W;
    localparam int D_W   = tps_pkg::D_W;
    localparam int N_ENT = tps_pkg::N_ENT;
    localparam int N_SQ  = tps_pkg::N_SQ;

    // valid bits of the early stages
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    tps_pkg::ctl_t ctl5_reg, ctl6_reg, ctl7_reg, ctl8_reg;
    tps_pkg::ctl_t ctl5_next;

    logic signed [CRD_W-1:0] crd_reg  [0:8];
    logic signed [CRD_W-1:0] crd_next [0:8];
    logic signed [DIF_W-1:0] u_reg [0:2];
    logic signed [DIF_W-1:0] v_reg [0:2];
    logic signed [DIF_W-1:0] u_next [0:2];
    logic signed [DIF_W-1:0] v_next [0:2];
    logic signed [PRD_W-1:0] prd_reg  [0:14];
    logic signed [PRD_W-1:0] prd_next [0:14];
    logic signed [CR_W-1:0]  cr_reg  [0:2];
    logic signed [CR_W-1:0]  cr_next [0:2];
    logic signed [DOT_W-1:0] dot_reg  [0:2];
    logic signed [DOT_W-1:0] dot_next [0:2];
    logic [MAG_W-1:0] mag_reg  [0:N_SQ-1];
    logic [MAG_W-1:0] mag_next [0:N_SQ-1];
    logic [MAG_W-1:0] pp_reg  [0:N_SQ-1][0:2];
    logic [MAG_W-1:0] pp_next [0:N_SQ-1][0:2];
    logic [SQ_W-1:0]  sq_reg  [0:N_SQ-1];
    logic [SQ_W-1:0]  sq_next [0:N_SQ-1];
    logic [D_W-1:0]   d_reg, d_next;
    logic [SQ_W-1:0]  m2_reg [0:N_ENT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
            ctl8_reg <= '0;
        end
        else if (en)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            ctl5_reg <= ctl5_next;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
            ctl8_reg <= ctl7_reg;
        end
    end

    // stage 1: unpack, drop z in planar mode
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            crd_next[i] = in_data[i*CRD_W +: CRD_W];
            if (planar && (i % 3 == 2))
                crd_next[i] = '0;
        end
    end

    // stage 2: edges
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = DIF_W'(crd_reg[3+i]) - DIF_W'(crd_reg[i]);
            v_next[i] = DIF_W'(crd_reg[6+i]) - DIF_W'(crd_reg[i]);
        end
    end

    // stage 3: all products
    always_comb
    begin
        prd_next[0] = u_reg[1] * v_reg[2];
        prd_next[1] = u_reg[2] * v_reg[1];
        prd_next[2] = u_reg[2] * v_reg[0];
        prd_next[3] = u_reg[0] * v_reg[2];
        prd_next[4] = u_reg[0] * v_reg[1];
        prd_next[5] = u_reg[1] * v_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            prd_next[6+i]  = u_reg[i] * u_reg[i];
            prd_next[9+i]  = v_reg[i] * v_reg[i];
            prd_next[12+i] = u_reg[i] * v_reg[i];
        end
    end

    // stage 4: cross product and Gram entries
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            cr_next[i] = CR_W'(prd_reg[2*i]) - CR_W'(prd_reg[2*i+1]);
        for (int j = 0; j < 3; j++)
            dot_next[j] = DOT_W'(prd_reg[6+3*j]) + DOT_W'(prd_reg[7+3*j])
                        + DOT_W'(prd_reg[8+3*j]);
    end

    // stage 5: entry numerators, split into sign and magnitude
    always_comb
    begin
        logic signed [N_W-1:0] d11, d22, d12;
        logic signed [N_W-1:0] n   [0:N_ENT-1];
        logic signed [N_W-1:0] abs_n;
        logic signed [CR_W-1:0] abs_c;
        d11 = N_W'(dot_reg[0]);
        d22 = N_W'(dot_reg[1]);
        d12 = N_W'(dot_reg[2]);
        n[0] = d11 + d22 - (d12 <<< 1);
        n[1] = d12 - d22;
        n[2] = d22;
        n[3] = d12 - d11;
        n[4] = -d12;
        n[5] = d11;
        ctl5_next.valid = v4_reg;
        ctl5_next.degen = (cr_reg[0] == '0) && (cr_reg[1] == '0) && (cr_reg[2] == '0);
        for (int i = 0; i < 3; i++)
        begin
            abs_c       = cr_reg[i][CR_W-1] ? -cr_reg[i] : cr_reg[i];
            mag_next[i] = MAG_W'(abs_c);
        end
        for (int i = 0; i < N_ENT; i++)
        begin
            ctl5_next.neg[i] = n[i][N_W-1];
            abs_n            = n[i][N_W-1] ? -n[i] : n[i];
            mag_next[3+i]    = abs_n[MAG_W-1:0];
        end
    end

    // stage 6: partial products of each square
    always_comb
    begin
        logic [HLF_W-1:0] hi, lo;
        for (int i = 0; i < N_SQ; i++)
        begin
            hi = mag_reg[i][MAG_W-1:HLF_W];
            lo = mag_reg[i][HLF_W-1:0];
            pp_next[i][0] = MAG_W'(hi) * MAG_W'(hi);
            pp_next[i][1] = MAG_W'(hi) * MAG_W'(lo);
            pp_next[i][2] = MAG_W'(lo) * MAG_W'(lo);
        end
    end

    // stage 7: combine partial products
    always_comb
    begin
        for (int i = 0; i < N_SQ; i++)
            sq_next[i] = (SQ_W'(pp_reg[i][0]) << (2*HLF_W))
                       + (SQ_W'(pp_reg[i][1]) << (HLF_W+1))
                       + SQ_W'(pp_reg[i][2]);
    end

    // stage 8: Gram determinant
    assign d_next = D_W'(sq_reg[0]) + D_W'(sq_reg[1]) + D_W'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crd_reg <= crd_next;
            u_reg   <= u_next;
            v_reg   <= v_next;
            prd_reg <= prd_next;
            cr_reg  <= cr_next;
            dot_reg <= dot_next;
            mag_reg <= mag_next;
            pp_reg  <= pp_next;
            sq_reg  <= sq_next;
            d_reg   <= d_next;
            for (int i = 0; i < N_ENT; i++)
                m2_reg[i] <= sq_reg[3+i];
        end
    end

    assign out_ctl = ctl8_reg;
    assign out_d   = d_reg;
    assign out_m2  = m2_reg;

endmodule

// ===== rtl/tps_root_step.sv =====
// One bit of y = floor(sqrt(T / D)) for all entries, MSB first.
// R holds T - y^2 D, P holds y D.
module tps_root_step #(
    parameter int BIT = 0,
    parameter int R_W = 136
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  tps_pkg::ctl_t             in_ctl,
    input  logic [tps_pkg::D_W-1:0]   in_d,
    input  logic [R_W-1:0]            in_r [0:tps_pkg::N_ENT-1],
    input  logic [tps_pkg::P_W-1:0]   in_p [0:tps_pkg::N_ENT-1],
    input  logic [tps_pkg::Y_W-1:0]   in_y [0:tps_pkg::N_ENT-1],
    output tps_pkg::ctl_t             out_ctl,
    output logic [tps_pkg::D_W-1:0]   out_d,
    output logic [R_W-1:0]            out_r [0:tps_pkg::N_ENT-1],
    output logic [tps_pkg::P_W-1:0]   out_p [0:tps_pkg::N_ENT-1],
    output logic [tps_pkg::Y_W-1:0]   out_y [0:tps_pkg::N_ENT-1]
);

    localparam int N_ENT = tps_pkg::N_ENT;
    localparam int X_W   = tps_pkg::X_W;
    localparam int P_W   = tps_pkg::P_W;
    localparam int Y_W   = tps_pkg::Y_W;
    localparam int D_W   = tps_pkg::D_W;

    tps_pkg::ctl_t      ctl_reg;
    logic [D_W-1:0]     d_reg;
    logic [R_W-1:0]     r_reg  [0:N_ENT-1];
    logic [R_W-1:0]     r_next [0:N_ENT-1];
    logic [P_W-1:0]     p_reg  [0:N_ENT-1];
    logic [P_W-1:0]     p_next [0:N_ENT-1];
    logic [Y_W-1:0]     y_reg  [0:N_ENT-1];
    logic [Y_W-1:0]     y_next [0:N_ENT-1];

    always_comb
    begin
        logic [X_W-1:0] delta;
        for (int i = 0; i < N_ENT; i++)
        begin
            // (y + 2^BIT)^2 D - y^2 D
            delta = (X_W'(in_p[i]) << (BIT+1)) + (X_W'(in_d) << (2*BIT));
            if (delta <= X_W'(in_r[i]))
            begin
                r_next[i] = in_r[i] - R_W'(delta);
                p_next[i] = in_p[i] + (P_W'(in_d) << BIT);
                y_next[i] = in_y[i] | (Y_W'(1) << BIT);
            end
            else
            begin
                r_next[i] = in_r[i];
                p_next[i] = in_p[i];
                y_next[i] = in_y[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= in_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= in_d;
            r_reg <= r_next;
            p_reg <= p_next;
            y_reg <= y_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign out_d   = d_reg;
    assign out_r   = r_reg;
    assign out_p   = p_reg;
    assign out_y   = y_reg;

endmodule

// ===== rtl/triangle_p1_stiffness_element.sv =====
// Path from input word to output word: tps_geom, then the root search, then an output register.
// Throughput: one triangle per cycle unless stalled; the 33-stage bit-per-stage root search sets depth.
// The whole pipeline holds while an output word waits and m_axis_tready is low.
// Reset: rst_n async active low clears all valid bits and planar_mode to 0.
`include "assert_macros.svh"

module triangle_p1_stiffness_element #(
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,        // planar_mode
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz (24 bits each, ax lowest)
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // k00, k10, k11, k20, k21, k22 (32 bits each, k00 lowest)
    output logic [191:0] m_axis_tdata,
    // degenerate
    output logic         m_axis_tuser
);

    localparam int N_ENT = tps_pkg::N_ENT;
    localparam int SQ_W  = tps_pkg::SQ_W;
    localparam int D_W   = tps_pkg::D_W;
    localparam int P_W   = tps_pkg::P_W;
    localparam int Y_W   = tps_pkg::Y_W;
    localparam int OUT_W = tps_pkg::OUT_W;
    localparam int R_W   = SQ_W + 2 * OUT_FRAC_BITS;

    logic en;
    logic planar_reg;

    tps_pkg::ctl_t   geo_ctl;
    logic [D_W-1:0]  geo_d;
    logic [SQ_W-1:0] geo_m2 [0:N_ENT-1];

    tps_pkg::ctl_t   rt_ctl [0:Y_W];
    logic [D_W-1:0]  rt_d   [0:Y_W];
    logic [R_W-1:0]  rt_r   [0:Y_W][0:N_ENT-1];
    logic [P_W-1:0]  rt_p   [0:Y_W][0:N_ENT-1];
    logic [Y_W-1:0]  rt_y   [0:Y_W][0:N_ENT-1];

    logic                    out_valid_reg;
    logic                    out_degen_reg, out_degen_next;
    logic [N_ENT*OUT_W-1:0]  out_data_reg, out_data_next;

    // advance everything unless a finished word is stuck
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            planar_reg <= 1'b0;
        else if (cfg_we)
            planar_reg <= cfg_wdata;
    end

    tps_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .planar   (planar_reg),
        .out_ctl  (geo_ctl),
        .out_d    (geo_d),
        .out_m2   (geo_m2)
    );

    assign rt_ctl[0] = geo_ctl;
    assign rt_d[0]   = geo_d;

    for (genvar i = 0; i < N_ENT; i++)
    begin : g_seed
        assign rt_r[0][i] = R_W'(geo_m2[i]) << (2 * OUT_FRAC_BITS);
        assign rt_p[0][i] = '0;
        assign rt_y[0][i] = '0;
    end

    for (genvar s = 0; s < Y_W; s++)
    begin : g_root
        tps_root_step #(
            .BIT (Y_W - 1 - s),
            .R_W (R_W)
        ) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_ctl  (rt_ctl[s]),
            .in_d    (rt_d[s]),
            .in_r    (rt_r[s]),
            .in_p    (rt_p[s]),
            .in_y    (rt_y[s]),
            .out_ctl (rt_ctl[s+1]),
            .out_d   (rt_d[s+1]),
            .out_r   (rt_r[s+1]),
            .out_p   (rt_p[s+1]),
            .out_y   (rt_y[s+1])
        );
    end

    // round half away from zero: q = (y + 1) / 2, then clamp and apply sign
    always_comb
    begin
        logic [Y_W:0]   yp;
        logic [Y_W-1:0] q, cap, cl, res;
        out_degen_next = rt_ctl[Y_W].degen;
        for (int i = 0; i < N_ENT; i++)
        begin
            yp  = {1'b0, rt_y[Y_W][i]} + (Y_W+1)'(1);
            q   = yp[Y_W:1];
            cap = (Y_W'(1) << (OUT_W - 1)) - (rt_ctl[Y_W].neg[i] ? Y_W'(0) : Y_W'(1));
            cl  = (q > cap) ? cap : q;
            res = rt_ctl[Y_W].neg[i] ? -cl : cl;
            out_data_next[i*OUT_W +: OUT_W] = rt_ctl[Y_W].degen ? '0 : res[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= rt_ctl[Y_W].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg  <= out_data_next;
            out_degen_reg <= out_degen_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_degen_reg;

    `TPS_ASSERT(a_degen_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0), "degenerate word carries nonzero entries")
    `TPS_ASSERT(a_diag_nonneg, m_axis_tvalid |-> (!m_axis_tdata[31] && !m_axis_tdata[95] && !m_axis_tdata[191]), "negative diagonal entry")
    `TPS_ASSERT(a_stall_blocks, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken while output stuck")
    `TPS_ASSERT_NEXT(a_frozen_mid, !s_axis_tready, $stable(rt_ctl[Y_W/2].valid), "root pipeline moved during stall")

endmodule

// ===== sim/tb_triangle_p1_stiffness_element.sv =====
`timescale 1ns / 1ps

module tb_triangle_p1_stiffness_element;

    localparam int LATENCY     = 42;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 455;

    typedef struct {
        logic signed [tps_pkg::CRD_W-1:0] crd [tps_pkg::N_CRD];
    } tri_t;

    typedef struct {
        logic [tps_pkg::OUT_W-1:0] k [tps_pkg::N_ENT];
        logic                      degen;
    } stiff_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic         m_axis_tuser;

    tri_t   tri_pending [$];
    stiff_t stiff_expected [$];
    bit     planar_now;
    bit     idle_enable;
    bit     in_taken;
    int     in_gap;
    int     out_gap;
    int     err_count;
    int     cycle_count;

    triangle_p1_stiffness_element uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] abs_of(longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    // round(n * 2^(OUT_FRAC_BITS-1) / sqrt(d)) by searching the largest y with
    // (2y-1)^2 * d <= n^2 * 2^(2*OUT_FRAC_BITS), clamped to 32 bits
    function automatic logic [tps_pkg::OUT_W-1:0] scaled_entry(longint n, logic [191:0] d);
        logic [191:0] m;
        logic [191:0] target;
        logic [191:0] odd;
        logic [191:0] lhs;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        m = 192'(abs_of(n));
        target = (m * m) << 32;
        lo = 0;
        hi = (n < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 192'(2 * mid - 1);
            lhs = odd * odd * d;
            if (lhs <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (n < 0)
            lo = -lo;
        return lo[tps_pkg::OUT_W-1:0];
    endfunction

    function automatic stiff_t stiffness_of(tri_t t, bit planar);
        stiff_t       r;
        longint       p [tps_pkg::N_CRD];
        longint       u [3];
        longint       v [3];
        longint       cr [3];
        longint       d11;
        longint       d22;
        longint       d12;
        logic [191:0] dd;
        logic [191:0] cm;
        for (int i = 0; i < tps_pkg::N_CRD; i++)
            p[i] = longint'(t.crd[i]);
        if (planar)
        begin
            p[2] = 0;
            p[5] = 0;
            p[8] = 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            u[i] = p[3+i] - p[i];
            v[i] = p[6+i] - p[i];
        end
        cr[0] = u[1] * v[2] - u[2] * v[1];
        cr[1] = u[2] * v[0] - u[0] * v[2];
        cr[2] = u[0] * v[1] - u[1] * v[0];
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0)
        begin
            foreach (r.k[i])
                r.k[i] = '0;
            r.degen = 1'b1;
            return r;
        end
        dd = '0;
        for (int i = 0; i < 3; i++)
        begin
            cm = 192'(abs_of(cr[i]));
            dd = dd + cm * cm;
        end
        d11 = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
        d22 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        d12 = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
        r.k[0] = scaled_entry(d11 + d22 - 2 * d12, dd);
        r.k[1] = scaled_entry(d12 - d22, dd);
        r.k[2] = scaled_entry(d22, dd);
        r.k[3] = scaled_entry(d12 - d11, dd);
        r.k[4] = scaled_entry(-d12, dd);
        r.k[5] = scaled_entry(d11, dd);
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic push_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz);
        tri_t t;
        t.crd[0] = ax[23:0]; t.crd[1] = ay[23:0]; t.crd[2] = az[23:0];
        t.crd[3] = bx[23:0]; t.crd[4] = by[23:0]; t.crd[5] = bz[23:0];
        t.crd[6] = cx[23:0]; t.crd[7] = cy[23:0]; t.crd[8] = cz[23:0];
        tri_pending.push_back(t);
    endtask

    task automatic push_directed();
        int mx;
        int mn;
        mx = 8388607;
        mn = -8388608;
        push_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);                     // coincident
        push_tri(0, 0, 0, 1 << 20, 0, 0, 0, 1 << 20, 0);         // unit right triangle
        push_tri(0, 0, 0, 1 << 20, 0, 0, 2 << 20, 0, 0);         // collinear
        push_tri(0, 0, 0, 0, 0, 1 << 20, 0, 1 << 20, 0);         // flat under planar mode
        push_tri(mn, mn, mn, mx, mn, mn, mn, mx, mx);
        push_tri(mx, mx, mx, mn, mx, mx, mx, mn, mn);
        push_tri(mn, mn, mn, mx, mx, mx, mx, mx, mx - 1);
        push_tri(0, 0, 0, mx, mx, 0, mx, mx - 1, 0);             // saturates high
        push_tri(0, 0, 0, 1, 0, 0, 0, 1, 0);                     // one-lsb triangle
        push_tri(0, 0, 0, mx, 0, 0, mx / 2, 1, 0);               // sliver, saturates
        push_tri(0, 0, 0, mx, 0, 0, mn, 1, 0);                   // obtuse, negative clamp
        push_tri(-1, -1, -1, mx, mn, mx, mn, mx, mn);
        push_tri(mx, mn, 0, mn, mx, 0, 0, 0, mx);
        push_tri(12345, -6789, 1000, -54321, 9876, -2000, 777, 888, -999);
    endtask

    task automatic push_random(input int count);
        int a [3];
        int b [3];
        int c [3];
        int kind;
        int span;
        repeat (count)
        begin
            kind = $urandom_range(0, 9);
            span = 1 << $urandom_range(0, 23);
            for (int i = 0; i < 3; i++)
            begin
                a[i] = $urandom;
                b[i] = $urandom;
                c[i] = $urandom;
                if (kind >= 4 && kind < 8)
                begin
                    b[i] = a[i] + $urandom_range(0, span) - span / 2;
                    c[i] = a[i] + $urandom_range(0, span) - span / 2;
                end
                else if (kind >= 8)
                begin
                    // near the line through a and b
                    b[i] = a[i] + $urandom_range(0, span) - span / 2;
                    c[i] = a[i] + 2 * (b[i] - a[i]) + $urandom_range(0, 2) - 1;
                end
            end
            push_tri(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]);
        end
    endtask

    task automatic wait_drained();
        while (tri_pending.size() != 0 || stiff_expected.size() != 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    task automatic write_planar(input bit mode);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we     <= 1'b0;
        planar_now = mode;
    endtask

    // input side: hold a word until taken, idle in random bursts
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap        <= in_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                in_gap        <= $urandom_range(0, 6);
                s_axis_tvalid <= 1'b0;
            end
            else if (tri_pending.size() != 0)
            begin
                for (int i = 0; i < tps_pkg::N_CRD; i++)
                    s_axis_tdata[24*i +: 24] <= tri_pending[0].crd[i];
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (out_gap > 0)
        begin
            out_gap       <= out_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            out_gap       <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        stiff_t want;
        in_taken = s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            stiff_expected.push_back(stiffness_of(tri_pending[0], planar_now));
            void'(tri_pending.pop_front());
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (stiff_expected.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected output word: %h user %b", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = stiff_expected.pop_front();
                for (int i = 0; i < tps_pkg::N_ENT; i++)
                begin
                    if (m_axis_tdata[32*i +: 32] !== want.k[i])
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("entry %0d mismatch: expected %h got %h",
                                     i, want.k[i], m_axis_tdata[32*i +: 32]);
                    end
                end
                if (m_axis_tuser !== want.degen)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("degenerate mismatch: expected %b got %b",
                                 want.degen, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_triangle_p1_stiffness_element: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        planar_now    = 1'b0;
        idle_enable   = 1'b1;
        in_taken      = 1'b0;
        in_gap        = 0;
        out_gap       = 0;
        err_count     = 0;
        cycle_count   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_planar(1'b0);
        push_directed();
        push_random(PHASE_ITEMS);
        wait_drained();
        repeat (LATENCY) @(posedge clk);

        write_planar(1'b1);
        push_directed();
        push_random(PHASE_ITEMS);
        wait_drained();
        repeat (LATENCY) @(posedge clk);

        write_planar(1'b0);
        push_random(PHASE_ITEMS);
        wait_drained();
        repeat (LATENCY) @(posedge clk);

        // last stretch at full rate on both sides
        write_planar(1'b1);
        idle_enable = 1'b0;
        push_random(PHASE_ITEMS);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);

        if (err_count == 0 && stiff_expected.size() == 0)
            $display("tb_triangle_p1_stiffness_element: PASS");
        else
            $display("tb_triangle_p1_stiffness_element: FAIL");
        $finish;
    end

endmodule
